/* rtl/tcw_pkg.sv */
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int DEF_COLS     = 80;
  localparam int DEF_ROWS     = 25;
  localparam int DEF_TAB_STOP = 8;

  localparam int REQ_W       = 2;
  localparam int CH_W        = 8;
  localparam int ADDR_W      = 11;
  localparam int DATA_W      = 16;
  localparam int IDX_W       = 11;
  localparam int COLOR_W     = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int OP_W        = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BG       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FG       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_BG = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_FG = 2'd3;

  localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;
  localparam logic [COLOR_W-1:0] FG_RESET = 4'h7;

  // classified commands handed from front to back
  localparam logic [OP_W-1:0] OP_NOP   = 3'd0;
  localparam logic [OP_W-1:0] OP_PRINT = 3'd1;
  localparam logic [OP_W-1:0] OP_BS    = 3'd2;
  localparam logic [OP_W-1:0] OP_TAB   = 3'd3;
  localparam logic [OP_W-1:0] OP_NL    = 3'd4;
  localparam logic [OP_W-1:0] OP_CR    = 3'd5;
  localparam logic [OP_W-1:0] OP_READ  = 3'd6;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd7;

  localparam logic [CH_W-1:0] CH_BS    = 8'h08;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_DEL   = 8'h7F;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CH_W-1:0]   ch;
    logic [ADDR_W-1:0] addr;
  } tcw_cmd_t;

  typedef struct packed {
    logic [COLOR_W-1:0] bg;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] blank_bg;
    logic [COLOR_W-1:0] blank_fg;
  } tcw_colors_t;

endpackage

/* rtl/tcw_front.sv */
`timescale 1ns / 1ps
module tcw_front #(
  parameter int COLS = tcw_pkg::DEF_COLS,
  parameter int ROWS = tcw_pkg::DEF_ROWS
) (
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tcw_pkg::REQ_W-1:0]   req_type,
  input  logic [tcw_pkg::CH_W-1:0]    char_code,
  input  logic [tcw_pkg::ADDR_W-1:0]  cell_address,
  input  logic                        q_full,
  input  logic                        clearing,
  output logic                        push,
  output tcw_pkg::tcw_cmd_t           push_cmd
);
  import tcw_pkg::*;

  localparam int CELLS = COLS * ROWS;

  assign in_stall = q_full | clearing;
  assign push     = in_valid & ~in_stall;

  always_comb begin
    push_cmd.ch   = char_code;
    push_cmd.addr = cell_address;
    push_cmd.op   = OP_NOP;
    case (req_type)
      REQ_PUT: begin
        if (char_code == CH_BS) begin
          push_cmd.op = OP_BS;
        end else if (char_code == CH_TAB) begin
          push_cmd.op = OP_TAB;
        end else if (char_code == CH_NL) begin
          push_cmd.op = OP_NL;
        end else if (char_code == CH_CR) begin
          push_cmd.op = OP_CR;
        end else if (char_code inside {[CH_SPACE:CH_DEL]}) begin
          push_cmd.op = OP_PRINT;
        end
      end
      REQ_READ: begin
        // reads past the store return zero
        if (int'(cell_address) < CELLS) begin
          push_cmd.op = OP_READ;
        end
      end
      REQ_CLEAR: begin
        push_cmd.op = OP_CLEAR;
      end
      default: begin
        push_cmd.op = OP_NOP;
      end
    endcase
  end

endmodule

/* rtl/tcw_queue.sv */
`timescale 1ns / 1ps
module tcw_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tcw_pkg::tcw_cmd_t push_cmd,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output tcw_pkg::tcw_cmd_t head_cmd
);
  import tcw_pkg::*;

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  tcw_cmd_t        entries [QUEUE_DEPTH];
  logic [QW-1:0]   wr_ptr;
  logic [QW-1:0]   rd_ptr;
  logic [NW-1:0]   count;

  assign full      = (count == NW'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_cmd  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* rtl/tcw_back.sv */
`timescale 1ns / 1ps
module tcw_back #(
  parameter int COLS     = tcw_pkg::DEF_COLS,
  parameter int ROWS     = tcw_pkg::DEF_ROWS,
  parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tcw_pkg::tcw_colors_t       colors,
  input  logic                       q_valid,
  input  tcw_pkg::tcw_cmd_t          cmd,
  output logic                       pop,
  output logic                       clearing,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [tcw_pkg::DATA_W-1:0] cell_data,
  output logic [tcw_pkg::IDX_W-1:0]  cursor_index
);
  import tcw_pkg::*;

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int PW    = (TAB_STOP > 2) ? $clog2(TAB_STOP) : 1;

  localparam logic [AW-1:0] LAST_COPY  = AW'(CELLS - COLS - 1);
  localparam logic [AW-1:0] FILL_START = AW'(CELLS - COLS);
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] ROW_STEP   = AW'(COLS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TAB    = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_SCR_RD = 3'd3;
  localparam logic [2:0] S_SCR_WR = 3'd4;
  localparam logic [2:0] S_FILL   = 3'd5;
  localparam logic [2:0] S_READ   = 3'd6;
  localparam logic [2:0] S_RESULT = 3'd7;

  logic [2:0]        state, state_next;
  logic [CW-1:0]     col, col_next;
  logic [RW-1:0]     row, row_next;
  logic [PW-1:0]     phase, phase_next;
  logic [AW-1:0]     ptr, ptr_next;
  logic              init, init_next;
  logic [DATA_W-1:0] data, data_next;

  logic [DATA_W-1:0] mem [CELLS];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] rdata;

  logic [AW-1:0]     cur;
  logic              last_col;
  logic              tab_end;
  logic [CW-1:0]     col_adv;
  logic [RW-1:0]     row_adv;
  logic [PW-1:0]     phase_adv;
  logic              load;
  logic [DATA_W-1:0] space_cell;
  logic [DATA_W-1:0] blank_cell;

  assign clearing   = init;
  assign cur        = AW'(AW'(row) * ROW_STEP + AW'(col));
  assign last_col   = (col == CW'(COLS - 1));
  assign tab_end    = last_col | (phase == PW'(TAB_STOP - 1));
  assign space_cell = {colors.bg, colors.fg, CH_SPACE};
  assign blank_cell = {colors.blank_bg, colors.blank_fg, CH_SPACE};

  // one step right, wrapping onto the next line at the right edge
  always_comb begin
    if (last_col) begin
      col_adv   = '0;
      row_adv   = row + 1'b1;
      phase_adv = '0;
    end else begin
      col_adv   = col + 1'b1;
      row_adv   = row;
      phase_adv = (phase == PW'(TAB_STOP - 1)) ? '0 : phase + 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    col_next   = col;
    row_next   = row;
    phase_next = phase;
    ptr_next   = ptr;
    init_next  = init;
    data_next  = data;
    mem_we     = 1'b0;
    mem_waddr  = cur;
    mem_wdata  = space_cell;
    mem_raddr  = ptr;
    pop        = 1'b0;
    load       = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          pop       = 1'b1;
          data_next = '0;
          case (cmd.op)
            OP_PRINT: begin
              mem_we     = 1'b1;
              mem_wdata  = {colors.bg, colors.fg, cmd.ch};
              col_next   = col_adv;
              row_next   = row_adv;
              phase_next = phase_adv;
              state_next = S_CHECK;
            end
            OP_BS: begin
              mem_we    = 1'b1;
              mem_wdata = blank_cell;
              if (col != '0) begin
                mem_waddr  = cur - 1'b1;
                col_next   = col - 1'b1;
                phase_next = (phase == '0) ? PW'(TAB_STOP - 1) : phase - 1'b1;
              end
              state_next = S_RESULT;
            end
            OP_TAB: begin
              state_next = S_TAB;
            end
            OP_NL: begin
              col_next   = '0;
              phase_next = '0;
              row_next   = row + 1'b1;
              state_next = S_CHECK;
            end
            OP_CR: begin
              col_next   = '0;
              phase_next = '0;
              state_next = S_RESULT;
            end
            OP_READ: begin
              mem_raddr  = AW'(cmd.addr);
              state_next = S_READ;
            end
            OP_CLEAR: begin
              col_next   = '0;
              row_next   = '0;
              phase_next = '0;
              ptr_next   = '0;
              state_next = S_FILL;
            end
            default: begin
              state_next = S_RESULT;
            end
          endcase
        end
      end
      S_TAB: begin
        mem_we     = 1'b1;
        col_next   = col_adv;
        row_next   = row_adv;
        phase_next = phase_adv;
        if (tab_end) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (row == RW'(ROWS)) begin
          ptr_next   = '0;
          state_next = S_SCR_RD;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_SCR_RD: begin
        mem_raddr  = ptr + ROW_STEP;
        state_next = S_SCR_WR;
      end
      S_SCR_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = rdata;
        if (ptr == LAST_COPY) begin
          ptr_next   = FILL_START;
          row_next   = row - 1'b1;
          state_next = S_FILL;
        end else begin
          ptr_next   = ptr + 1'b1;
          state_next = S_SCR_RD;
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = '0;
        if (ptr == LAST_CELL) begin
          if (init) begin
            init_next  = 1'b0;
            state_next = S_IDLE;
          end else begin
            state_next = S_RESULT;
          end
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      S_READ: begin
        data_next  = rdata;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid || !out_stall) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      col       <= '0;
      row       <= '0;
      phase     <= '0;
      ptr       <= '0;
      init      <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      col   <= col_next;
      row   <= row_next;
      phase <= phase_next;
      ptr   <= ptr_next;
      init  <= init_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    if (load) begin
      cell_data    <= data;
      cursor_index <= IDX_W'(cur);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

endmodule

/* rtl/text_console_writer_core.sv */
`timescale 1ns / 1ps
// Text console over a COLS x ROWS store of 16-bit cells (attribute byte high, character
// low), driven by put-character, read-cell and clear requests; every request returns one
// result with the cell read (zero otherwise) and the linear cursor index. A front end
// classifies requests into a two-entry command queue and a sequencer executes them against
// a store with one write port and registered read data. After reset the store is cleared
// with in_stall held high. A tab writes spaces up to the next tab stop, and a put that
// scrolls moves the lines up one row and clears the bottom row.
module text_console_writer_core #(
  parameter int COLS     = tcw_pkg::DEF_COLS,
  parameter int ROWS     = tcw_pkg::DEF_ROWS,
  parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tcw_pkg::REQ_W-1:0]     req_type,
  input  logic [tcw_pkg::CH_W-1:0]      char_code,
  input  logic [tcw_pkg::ADDR_W-1:0]    cell_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tcw_pkg::DATA_W-1:0]    cell_data,
  output logic [tcw_pkg::IDX_W-1:0]     cursor_index
);
  import tcw_pkg::*;

  tcw_colors_t colors;
  tcw_cmd_t    push_cmd;
  tcw_cmd_t    head_cmd;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_valid;
  logic        clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      colors.bg       <= BG_RESET;
      colors.fg       <= FG_RESET;
      colors.blank_bg <= BG_RESET;
      colors.blank_fg <= FG_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BG:       colors.bg       <= cfg_data;
        CFG_FG:       colors.fg       <= cfg_data;
        CFG_BLANK_BG: colors.blank_bg <= cfg_data;
        CFG_BLANK_FG: colors.blank_fg <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tcw_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .char_code    (char_code),
    .cell_address (cell_address),
    .q_full       (q_full),
    .clearing     (clearing),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  tcw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head_cmd  (head_cmd)
  );

  tcw_back #(
    .COLS     (COLS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .colors       (colors),
    .q_valid      (q_valid),
    .cmd          (head_cmd),
    .pop          (pop),
    .clearing     (clearing),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cell_data    (cell_data),
    .cursor_index (cursor_index)
  );

endmodule

/* rtl/tcw_checker.sv */
`timescale 1ns / 1ps
module tcw_checker #(
  parameter int COLS = tcw_pkg::DEF_COLS,
  parameter int ROWS = tcw_pkg::DEF_ROWS
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [tcw_pkg::DATA_W-1:0] cell_data,
  input logic [tcw_pkg::IDX_W-1:0]  cursor_index
);
  import tcw_pkg::*;

  localparam int CELLS = COLS * ROWS;

  // a held result keeps its value until the transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cell_data) && $stable(cursor_index))
    else $error("result changed while stalled");

  // cursor always lands inside the store
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(cursor_index) < CELLS)
    else $error("cursor index outside the store");

  // reset starts the store clearing pass with nothing to deliver
  a_reset_clear: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("input open or result pending after reset");

endmodule

bind text_console_writer_core tcw_checker #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_tcw_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .cell_data    (cell_data),
  .cursor_index (cursor_index)
);

/* dv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import tcw_pkg::*;

  localparam int COLS        = DEF_COLS;
  localparam int ROWS        = DEF_ROWS;
  localparam int TAB_STOP    = DEF_TAB_STOP;
  localparam int CELLS       = COLS * ROWS;
  localparam int STALL_LIMIT = 20000;
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_ITEMS = 160;
  localparam int N_DIRECTED  = 27;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [IDX_W-1:0]  cursor;
  } result_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [CH_W-1:0]   ch;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        reps;
    logic              typed;
    logic [DATA_W-1:0] data;
    logic [IDX_W-1:0]  cursor;
  } step_t;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = CFG_BG;
  logic [COLOR_W-1:0]   cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [REQ_W-1:0]     req_type     = REQ_PUT;
  logic [CH_W-1:0]      char_code    = '0;
  logic [ADDR_W-1:0]    cell_address = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [DATA_W-1:0]    cell_data;
  logic [IDX_W-1:0]     cursor_index;

  // console image kept by the testbench
  logic [DATA_W-1:0]  screen [CELLS];
  int                 cur_col = 0;
  int                 cur_row = 0;
  logic [COLOR_W-1:0] pen_bg   = BG_RESET;
  logic [COLOR_W-1:0] pen_fg   = FG_RESET;
  logic [COLOR_W-1:0] blank_bg = BG_RESET;
  logic [COLOR_W-1:0] blank_fg = FG_RESET;

  result_t results_due [$];
  int      errors        = 0;
  int      accepted_reqs = 0;
  int      burst_left    = 0;
  int      idle_cycles   = 0;
  bit      hold_off_go   = 1'b0;

  text_console_writer_core #(
    .COLS(COLS),
    .ROWS(ROWS),
    .TAB_STOP(TAB_STOP)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .char_code(char_code),
    .cell_address(cell_address),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cell_data(cell_data),
    .cursor_index(cursor_index)
  );

  always #5 clk = ~clk;

  function automatic void store_cell(input int idx, input logic [DATA_W-1:0] v);
    if (idx < CELLS) begin
      screen[idx] = v;
    end
  endfunction

  // wrap at the right edge, scroll while past the bottom row
  function automatic void settle_cursor();
    if (cur_col >= COLS) begin
      cur_col = 0;
      cur_row++;
    end
    while (cur_row >= ROWS) begin
      for (int i = 0; i < (ROWS - 1) * COLS; i++) begin
        screen[i] = screen[i + COLS];
      end
      for (int i = (ROWS - 1) * COLS; i < CELLS; i++) begin
        screen[i] = '0;
      end
      if (cur_row > 0) begin
        cur_row--;
      end
    end
  endfunction

  function automatic void print_at_cursor(input logic [CH_W-1:0] ch);
    store_cell(cur_row * COLS + cur_col, {pen_bg, pen_fg, ch});
    cur_col++;
    settle_cursor();
  endfunction

  function automatic void console_apply(input logic [REQ_W-1:0] req,
                                        input logic [CH_W-1:0] ch,
                                        input logic [ADDR_W-1:0] addr,
                                        output result_t res);
    int stop;
    int n;
    res.data = '0;
    if (req == REQ_PUT) begin
      if (ch == CH_BS) begin
        if (cur_col > 0) begin
          store_cell(cur_row * COLS + cur_col - 1, {blank_bg, blank_fg, CH_SPACE});
          cur_col--;
        end else begin
          store_cell(cur_row * COLS + cur_col, {blank_bg, blank_fg, CH_SPACE});
        end
      end else if (ch == CH_TAB) begin
        stop = (cur_col / TAB_STOP + 1) * TAB_STOP;
        if (stop > COLS) begin
          stop = COLS;
        end
        n = (stop > cur_col) ? stop - cur_col : 0;
        for (int i = 0; i < n; i++) begin
          print_at_cursor(CH_SPACE);
        end
      end else if (ch == CH_NL) begin
        cur_row++;
        cur_col = 0;
      end else if (ch == CH_CR) begin
        cur_col = 0;
      end else if (ch >= CH_SPACE && ch <= CH_DEL) begin
        print_at_cursor(ch);
      end
      settle_cursor();
    end else if (req == REQ_READ) begin
      if (int'(addr) < CELLS) begin
        res.data = screen[addr];
      end
    end else if (req == REQ_CLEAR) begin
      for (int i = 0; i < CELLS; i++) begin
        screen[i] = '0;
      end
      cur_col = 0;
      cur_row = 0;
    end
    res.cursor = IDX_W'(cur_row * COLS + cur_col);
  endfunction

  // one request transfer; the sender runs in bursts with gaps, sometimes none, between them
  task automatic send_req(input logic [REQ_W-1:0] req, input logic [CH_W-1:0] ch,
                          input logic [ADDR_W-1:0] addr);
    int      gap;
    result_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_type     <= req;
    char_code    <= ch;
    cell_address <= addr;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall);
    accepted_reqs++;
    console_apply(req, ch, addr, res);
    results_due.push_back(res);
  endtask

  task automatic set_colours(input logic [15:0] c);
    cfg_write <= 1'b1;
    cfg_index <= CFG_BG;
    cfg_data  <= c[15:12];
    @(posedge clk);
    cfg_index <= CFG_FG;
    cfg_data  <= c[11:8];
    @(posedge clk);
    cfg_index <= CFG_BLANK_BG;
    cfg_data  <= c[7:4];
    @(posedge clk);
    cfg_index <= CFG_BLANK_FG;
    cfg_data  <= c[3:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    {pen_bg, pen_fg, blank_bg, blank_fg} = c;
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      screen[i] = '0;
    end
  end

  // receiver: stall pattern changes every so often, with one long hold-off on request
  initial begin : receiver
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        out_stall <= 1'b1;
        repeat ($urandom_range(300, 500)) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 300);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= ((left % 5) < 2);
          default: out_stall <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("result with nothing pending: cell_data %h cursor %0d",
                   cell_data, cursor_index);
        end
      end else begin
        want = results_due.pop_front();
        if (cell_data !== want.data || cursor_index !== want.cursor) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("mismatch: cell_data %h cursor %0d, expected %h %0d",
                     cell_data, cursor_index, want.data, want.cursor);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : stimulus
    step_t       directed [N_DIRECTED];
    step_t       row;
    logic [15:0] phase_colours [5];
    int          target;
    int          kind;
    int          r;
    int          len;
    int          ch;
    int          addr;

    directed = '{
      '{REQ_READ,   8'h00,  11'd0,    8'd1,  1'b1, 16'h0000, 11'd0},
      '{REQ_READ,   8'hFF,  11'd1999, 8'd1,  1'b1, 16'h0000, 11'd0},
      '{REQ_READ,   8'h00,  11'd2047, 8'd1,  1'b1, 16'h0000, 11'd0},
      '{REQ_PUT,    8'h41,  11'd0,    8'd1,  1'b1, 16'h0000, 11'd1},
      '{REQ_READ,   8'h00,  11'd0,    8'd1,  1'b1, 16'h0741, 11'd1},
      '{REQ_PUT,    CH_DEL, 11'd2047, 8'd1,  1'b1, 16'h0000, 11'd2},
      '{REQ_PUT,    8'h00,  11'd0,    8'd1,  1'b1, 16'h0000, 11'd2},
      '{REQ_PUT,    8'h1F,  11'd0,    8'd1,  1'b1, 16'h0000, 11'd2},
      '{REQ_PUT,    8'h80,  11'd0,    8'd1,  1'b1, 16'h0000, 11'd2},
      '{REQ_PUT,    8'hFF,  11'd0,    8'd1,  1'b1, 16'h0000, 11'd2},
      '{REQ_PUT,    CH_BS,  11'd0,    8'd1,  1'b1, 16'h0000, 11'd1},
      '{REQ_READ,   8'h00,  11'd1,    8'd1,  1'b1, 16'h0720, 11'd1},
      '{REQ_PUT,    CH_TAB, 11'd0,    8'd1,  1'b1, 16'h0000, 11'd8},
      '{REQ_PUT,    CH_CR,  11'd0,    8'd1,  1'b1, 16'h0000, 11'd0},
      '{REQ_PUT,    CH_BS,  11'd0,    8'd1,  1'b1, 16'h0000, 11'd0},
      '{REQ_READ,   8'h00,  11'd0,    8'd1,  1'b1, 16'h0720, 11'd0},
      '{REQ_PUT,    CH_NL,  11'd0,    8'd1,  1'b1, 16'h0000, 11'd80},
      '{REQ_UNUSED, 8'hAA,  11'd2047, 8'd1,  1'b1, 16'h0000, 11'd80},
      '{REQ_CLEAR,  8'h55,  11'd1365, 8'd1,  1'b1, 16'h0000, 11'd0},
      '{REQ_READ,   8'h00,  11'd0,    8'd1,  1'b1, 16'h0000, 11'd0},
      // down to the bottom row, fill it, then a tab that wraps and scrolls
      '{REQ_PUT,    CH_NL,  11'd0,    8'd24, 1'b0, 16'h0000, 11'd0},
      '{REQ_PUT,    8'h5A,  11'd0,    8'd79, 1'b0, 16'h0000, 11'd0},
      '{REQ_PUT,    CH_TAB, 11'd0,    8'd1,  1'b0, 16'h0000, 11'd0},
      '{REQ_READ,   8'h00,  11'd1840, 8'd1,  1'b0, 16'h0000, 11'd0},
      '{REQ_PUT,    CH_NL,  11'd0,    8'd2,  1'b0, 16'h0000, 11'd0},
      '{REQ_PUT,    8'h42,  11'd0,    8'd90, 1'b0, 16'h0000, 11'd0},
      '{REQ_READ,   8'h00,  11'd1999, 8'd1,  1'b0, 16'h0000, 11'd0}
    };
    phase_colours = '{16'hFFFF, 16'h0000, 16'(($urandom)), 16'hA53C, 16'(($urandom))};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = directed[i];
      for (int k = 0; k < int'(row.reps); k++) begin
        send_req(row.req, row.ch, row.addr);
        if (row.typed) begin
          results_due[results_due.size() - 1] = '{row.data, row.cursor};
        end
      end
    end

    for (int p = 0; p < 5; p++) begin
      // colours change only with nothing in flight
      in_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clk);
      repeat (20) @(posedge clk);
      set_colours(phase_colours[p]);
      if (p == 1 || p == 3) begin
        hold_off_go = 1'b1;
      end
      target = accepted_reqs + PHASE_ITEMS;
      while (accepted_reqs < target) begin
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
          // a line of text with some tabs, backspaces and junk bytes
          len = $urandom_range(0, 60);
          for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 82) begin
              ch = $urandom_range(32, 127);
            end else if (r < 88) begin
              ch = int'(CH_TAB);
            end else if (r < 95) begin
              ch = int'(CH_BS);
            end else begin
              ch = $urandom_range(128, 255);
            end
            send_req(REQ_PUT, CH_W'(ch), ADDR_W'($urandom_range(0, 2047)));
          end
          r = $urandom_range(0, 99);
          if (r < 20) begin
            send_req(REQ_PUT, CH_CR, ADDR_W'($urandom_range(0, 2047)));
          end
          if (r < 80) begin
            send_req(REQ_PUT, CH_NL, ADDR_W'($urandom_range(0, 2047)));
          end
        end else if (kind < 68) begin
          repeat ($urandom_range(1, 8)) begin
            send_req(REQ_PUT, CH_NL, ADDR_W'($urandom_range(0, 2047)));
          end
        end else if (kind < 85) begin
          repeat ($urandom_range(1, 4)) begin
            r = $urandom_range(0, 4);
            if (r == 0) begin
              addr = cur_row * COLS + cur_col - $urandom_range(0, 2);
              addr = (addr < 0) ? 0 : addr;
            end else if (r == 1) begin
              addr = $urandom_range(CELLS, 2047);
            end else if (r == 2) begin
              addr = $urandom_range(0, 1) ? CELLS - 1 : 0;
            end else begin
              addr = $urandom_range(0, CELLS - 1);
            end
            send_req(REQ_READ, CH_W'($urandom), ADDR_W'(addr));
          end
        end else if (kind < 93) begin
          // bytes the console drops, and the unused request type
          repeat ($urandom_range(1, 3)) begin
            r = $urandom_range(0, 3);
            if (r == 0) begin
              ch = $urandom_range(128, 255);
            end else if (r == 1) begin
              ch = $urandom_range(14, 31);
            end else begin
              ch = $urandom_range(0, 9);
              ch = (ch > 7) ? ch + 3 : ch;
            end
            if ($urandom_range(0, 2) == 0) begin
              send_req(REQ_UNUSED, CH_W'($urandom), ADDR_W'($urandom));
            end else begin
              send_req(REQ_PUT, CH_W'(ch), ADDR_W'($urandom));
            end
          end
        end else if (kind < 98) begin
          // backspace run from column zero
          send_req(REQ_PUT, CH_CR, ADDR_W'($urandom));
          repeat ($urandom_range(1, 4)) begin
            send_req(REQ_PUT, CH_BS, ADDR_W'($urandom));
          end
        end else begin
          send_req(REQ_CLEAR, CH_W'($urandom), ADDR_W'($urandom));
        end
      end
    end

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* text_console_writer_core.f */
rtl/tcw_pkg.sv
rtl/tcw_front.sv
rtl/tcw_queue.sv
rtl/tcw_back.sv
rtl/text_console_writer_core.sv
rtl/tcw_checker.sv
dv/testbench.sv
